// File: hw/rtl/assert_macros.svh
// Assertion shorthands for the response frame checker.
// Expects clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock, skipped while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/rfc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the response
// frame checker. No dependencies.
package rfc_pkg;

  localparam int MAX_PAYLOAD_DEF = 1024;

  localparam logic [31:0] FRAME_MAGIC   = 32'h5357_5052;
  localparam logic [7:0]  FRAME_VERSION = 8'h01;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [7:0]  REPLY_BIT     = 8'h80;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] VERDICT_OK         = 3'd0;
  localparam logic [2:0] VERDICT_BAD_HEADER = 3'd1;
  localparam logic [2:0] VERDICT_UNEXPECTED = 3'd2;
  localparam logic [2:0] VERDICT_BAD_CRC    = 3'd3;
  localparam logic [2:0] VERDICT_DEV_STATUS = 3'd4;
  localparam logic [2:0] VERDICT_TOO_LONG   = 3'd5;

  typedef struct packed {
    logic        op;
    logic [7:0]  cmd_id;
    logic [15:0] expected_seq;
    logic [10:0] max_len;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  verdict;
    logic [15:0] dev_status;
    logic [10:0] pay_len;
  } result_t;

  typedef struct packed {
    logic res_valid;
    logic frame_open;
  } eng_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/rfc_if.sv
// Valid/ready channels of the response frame checker: received items in,
// payload and verdict beats out. No dependencies.
interface rfc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  cmd_id;
  logic [15:0] expected_seq;
  logic [10:0] max_len;
  logic [7:0]  rx_byte;

  modport source(output valid, op, cmd_id, expected_seq, max_len, rx_byte, input ready);
  modport sink(input valid, op, cmd_id, expected_seq, max_len, rx_byte, output ready);
endinterface

interface rfc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [2:0]  verdict;
  logic [15:0] dev_status;
  logic [10:0] pay_len;

  modport source(output valid, kind, data_byte, verdict, dev_status, pay_len,
                 input ready);
  modport sink(input valid, kind, data_byte, verdict, dev_status, pay_len,
               output ready);
endinterface

// File: hw/rtl/rfc_engine.sv
// Frame state machine with CRC-32 update and the result register.
// Depends on rfc_pkg.
module rfc_engine #(
  parameter int MAX_PAYLOAD = rfc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  rfc_pkg::item_t      item,
  input  logic                pop,
  output rfc_pkg::result_t    result,
  output rfc_pkg::eng_stat_t  stat
);

  localparam int CW = $clog2(MAX_PAYLOAD + 3);
  localparam logic [15:0] LEN_MAX = 16'(MAX_PAYLOAD + 2);

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_BODY, PH_CRC} phase_t;

  phase_t           phase;
  logic [CW-1:0]    byte_count;
  logic [31:0]      crc_reg;
  logic             header_mismatch;
  logic [7:0]       want_cmd;
  logic [15:0]      want_seq;
  logic [10:0]      capacity;
  logic [7:0]       seen_cmd;
  logic [15:0]      seen_seq;
  logic [7:0]       len_lo;
  logic [CW-1:0]    body_len;
  logic [15:0]      status_word;
  logic [31:0]      received_crc;
  logic             res_valid;
  rfc_pkg::result_t res;

  logic [31:0]   crc_next;
  logic [CW-1:0] count_inc;
  logic [15:0]   len_full;
  logic [15:0]   plen;
  logic [31:0]   rcrc_full;
  logic [7:0]    magic_byte;
  logic          hdr_unexpected;
  logic [2:0]    final_verdict;
  logic          res_fire;

  assign crc_next   = rfc_pkg::crc_byte(crc_reg, item.rx_byte);
  assign count_inc  = byte_count + 1'b1;
  assign len_full   = {item.rx_byte, len_lo};
  assign plen       = 16'(body_len) - 16'd2;
  assign rcrc_full  = {item.rx_byte, received_crc[23:0]};
  assign magic_byte = 8'(rfc_pkg::FRAME_MAGIC >> {byte_count[1:0], 3'b000});

  assign hdr_unexpected = (seen_cmd != (want_cmd | rfc_pkg::REPLY_BIT)) ||
                          (seen_seq != want_seq) || (len_full < 16'd2) ||
                          (len_full > LEN_MAX);

  assign res_fire = step && (item.op == rfc_pkg::OP_BYTE) &&
                    (((phase == PH_HEADER) && (byte_count == CW'(9)) &&
                      (header_mismatch || hdr_unexpected)) ||
                     ((phase == PH_BODY) && (byte_count >= CW'(2))) ||
                     ((phase == PH_CRC) && (byte_count[1:0] == 2'd3)));

  always_comb begin
    if (~crc_reg != rcrc_full) begin
      final_verdict = rfc_pkg::VERDICT_BAD_CRC;
    end else if (status_word != 16'd0) begin
      final_verdict = rfc_pkg::VERDICT_DEV_STATUS;
    end else if (plen > 16'(capacity)) begin
      final_verdict = rfc_pkg::VERDICT_TOO_LONG;
    end else begin
      final_verdict = rfc_pkg::VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_count      <= '0;
      crc_reg         <= '1;
      header_mismatch <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      res_valid <= res_fire || (res_valid && !pop);
      if (step) begin
        if (item.op == rfc_pkg::OP_START) begin
          phase           <= PH_HEADER;
          byte_count      <= '0;
          crc_reg         <= '1;
          header_mismatch <= 1'b0;
          want_cmd        <= item.cmd_id;
          want_seq        <= item.expected_seq;
          capacity        <= item.max_len;
        end else begin
          unique case (phase)
            PH_IDLE: begin
            end
            PH_HEADER: begin
              crc_reg    <= crc_next;
              byte_count <= (byte_count == CW'(9)) ? '0 : count_inc;
              if (byte_count < CW'(4)) begin
                if (item.rx_byte != magic_byte) header_mismatch <= 1'b1;
              end else begin
                case (byte_count[3:0])
                  4'd4: if (item.rx_byte != rfc_pkg::FRAME_VERSION) header_mismatch <= 1'b1;
                  4'd5: seen_cmd <= item.rx_byte;
                  4'd6: seen_seq[7:0] <= item.rx_byte;
                  4'd7: seen_seq[15:8] <= item.rx_byte;
                  4'd8: len_lo <= item.rx_byte;
                  default: begin
                    if (header_mismatch || hdr_unexpected) begin
                      phase           <= PH_IDLE;
                      res.kind        <= rfc_pkg::KIND_VERDICT;
                      res.data_byte   <= 8'd0;
                      res.verdict     <= header_mismatch ? rfc_pkg::VERDICT_BAD_HEADER
                                                         : rfc_pkg::VERDICT_UNEXPECTED;
                      res.dev_status  <= 16'd0;
                      res.pay_len     <= 11'd0;
                    end else begin
                      body_len <= len_full[CW-1:0];
                      phase    <= PH_BODY;
                    end
                  end
                endcase
              end
            end
            PH_BODY: begin
              crc_reg    <= crc_next;
              byte_count <= (count_inc >= body_len) ? '0 : count_inc;
              if (byte_count == CW'(0)) begin
                status_word[7:0] <= item.rx_byte;
              end else if (byte_count == CW'(1)) begin
                status_word[15:8] <= item.rx_byte;
              end else begin
                res.kind       <= rfc_pkg::KIND_DATA;
                res.data_byte  <= item.rx_byte;
                res.verdict    <= rfc_pkg::VERDICT_OK;
                res.dev_status <= 16'd0;
                res.pay_len    <= 11'd0;
              end
              if (count_inc >= body_len) begin
                received_crc <= '0;
                phase        <= PH_CRC;
              end
            end
            PH_CRC: begin
              byte_count <= (byte_count[1:0] == 2'd3) ? '0 : count_inc;
              received_crc[{byte_count[1:0], 3'b000} +: 8] <= item.rx_byte;
              if (byte_count[1:0] == 2'd3) begin
                phase          <= PH_IDLE;
                res.kind       <= rfc_pkg::KIND_VERDICT;
                res.data_byte  <= 8'd0;
                res.verdict    <= final_verdict;
                res.dev_status <= status_word;
                res.pay_len    <= plen[10:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign result          = res;
  assign stat.res_valid  = res_valid;
  assign stat.frame_open = (phase != PH_IDLE);

endmodule

// File: hw/rtl/response_frame_checker_core.sv
// Top level of the response frame checker: input stage, handshakes, checks.
// Depends on rfc_pkg, rfc_if, rfc_engine and assert_macros.svh.
//
//   channel | dir | beat
//   rx      | in  | start (op 0: cmd, seq, capacity) or one received byte
//   res     | out | payload byte (kind 0) or verdict (kind 1)
//
// One beat per cycle sustained while res is not stalled; a beat goes from rx
// through the input stage, then the frame engine into the result register, to res.
// The byte-wide CRC-32 update sits between the input stage and the state.
// rst is synchronous and returns the checker to idle with both stages empty.
// A stalled res holds the input stage; rx then takes one more beat at most.
`include "assert_macros.svh"

module response_frame_checker_core #(
  parameter int MAX_PAYLOAD = rfc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic           clk,
  input  logic           rst,
  rfc_in_if.sink         rx,
  rfc_out_if.source      res
);

  logic               stage_valid;
  rfc_pkg::item_t     stage;
  logic               advance;
  logic               pop;
  rfc_pkg::result_t   result;
  rfc_pkg::eng_stat_t stat;

  assign pop      = res.valid && res.ready;
  assign advance  = stage_valid && (!stat.res_valid || res.ready);
  assign rx.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (rx.ready) begin
      stage_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      stage.op           <= rx.op;
      stage.cmd_id       <= rx.cmd_id;
      stage.expected_seq <= rx.expected_seq;
      stage.max_len      <= rx.max_len;
      stage.rx_byte      <= rx.rx_byte;
    end
  end

  rfc_engine #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .item  (stage),
    .pop   (pop),
    .result(result),
    .stat  (stat)
  );

  assign res.valid      = stat.res_valid;
  assign res.kind       = result.kind;
  assign res.data_byte  = result.data_byte;
  assign res.verdict    = result.verdict;
  assign res.dev_status = result.dev_status;
  assign res.pay_len    = result.pay_len;

  `ASSERT_CLK(a_data_in_frame,
              $rose(res.valid) && res.kind == rfc_pkg::KIND_DATA |-> stat.frame_open,
              "payload beat outside a frame")
  `ASSERT_CLK(a_verdict_closes,
              $rose(res.valid) && res.kind == rfc_pkg::KIND_VERDICT |-> !stat.frame_open,
              "frame still open after verdict")
  `ASSERT_CLK(a_stall_holds_stage,
              res.valid && !res.ready && stage_valid |=> stage_valid,
              "input stage dropped during output stall")

endmodule

// File: tb/sv/response_frame_checker_core_test.sv
// Self-checking testbench for response_frame_checker_core: builds response frames,
// predicts every payload and verdict beat, and checks them under random stalls.
// Depends on rfc_pkg, rfc_if and the response_frame_checker_core RTL.
module response_frame_checker_core_test;

  localparam int PAYLOAD_CAP = rfc_pkg::MAX_PAYLOAD_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 4000;

  typedef enum logic [1:0] {FR_IDLE, FR_HEADER, FR_BODY, FR_CRC} frame_phase_t;

  logic clk;
  logic rst;

  rfc_in_if  rx_ch();
  rfc_out_if res_ch();

  response_frame_checker_core #(.MAX_PAYLOAD(PAYLOAD_CAP)) dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .res(res_ch)
  );

  frame_phase_t fr_phase;
  int           fr_count;
  logic [31:0]  fr_crc;
  logic         fr_hdr_bad;
  logic [7:0]   fr_want_cmd;
  logic [15:0]  fr_want_seq;
  logic [10:0]  fr_cap;
  logic [15:0]  fr_seq;
  logic [7:0]   fr_cmd;
  logic [15:0]  fr_len;
  logic [15:0]  fr_status;
  logic [31:0]  fr_rx_crc;

  rfc_pkg::result_t pending_beats[$];
  logic [7:0]       frame_bytes[$];
  int               items_sent;
  int               mismatch_count;
  int               cycle_count;
  int               sink_hold;
  bit               sink_steady;
  bit               tx_steady;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] d);
    for (int k = 0; k < 8; k++) begin
      if (acc[0] ^ d[k]) acc = (acc >> 1) ^ rfc_pkg::CRC_POLY;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

  function automatic bit predict_beat(input rfc_pkg::item_t it, output rfc_pkg::result_t r);
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] plen;
    int          idx;
    bit          got;
    b = it.rx_byte;
    r = '0;
    got = 1'b0;
    if (it.op == rfc_pkg::OP_START) begin
      fr_phase = FR_HEADER;
      fr_count = 0;
      fr_crc = '1;
      fr_hdr_bad = 1'b0;
      fr_want_cmd = it.cmd_id;
      fr_want_seq = it.expected_seq;
      fr_cap = it.max_len;
      fr_seq = '0;
      fr_cmd = '0;
      fr_len = '0;
      fr_status = '0;
      fr_rx_crc = '0;
      return 1'b0;
    end
    case (fr_phase)
      FR_HEADER: begin
        idx = fr_count;
        fr_crc = crc32_step(fr_crc, b);
        fr_count++;
        case (idx)
          0, 1, 2, 3: if (b != rfc_pkg::FRAME_MAGIC[8*idx +: 8]) fr_hdr_bad = 1'b1;
          4: if (b != rfc_pkg::FRAME_VERSION) fr_hdr_bad = 1'b1;
          5: fr_cmd = b;
          6: fr_seq = {8'h00, b};
          7: fr_seq[15:8] = b;
          8: fr_len = {8'h00, b};
          default: begin
            len = {b, fr_len[7:0]};
            fr_count = 0;
            if (fr_hdr_bad) begin
              fr_phase = FR_IDLE;
              r.kind = rfc_pkg::KIND_VERDICT;
              r.verdict = rfc_pkg::VERDICT_BAD_HEADER;
              got = 1'b1;
            end else if (fr_cmd != (fr_want_cmd | rfc_pkg::REPLY_BIT) ||
                         fr_seq != fr_want_seq ||
                         len < 2 || len > PAYLOAD_CAP + 2) begin
              fr_phase = FR_IDLE;
              r.kind = rfc_pkg::KIND_VERDICT;
              r.verdict = rfc_pkg::VERDICT_UNEXPECTED;
              got = 1'b1;
            end else begin
              fr_len = len;
              fr_phase = FR_BODY;
            end
          end
        endcase
      end
      FR_BODY: begin
        idx = fr_count;
        fr_crc = crc32_step(fr_crc, b);
        fr_count++;
        if (idx == 0) fr_status = {8'h00, b};
        else if (idx == 1) fr_status[15:8] = b;
        else begin
          r.kind = rfc_pkg::KIND_DATA;
          r.data_byte = b;
          got = 1'b1;
        end
        if (fr_count >= fr_len) begin
          fr_count = 0;
          fr_rx_crc = '0;
          fr_phase = FR_CRC;
        end
      end
      FR_CRC: begin
        idx = fr_count % 4;
        fr_rx_crc[8*idx +: 8] = b;
        fr_count++;
        if (idx == 3) begin
          plen = fr_len - 16'd2;
          r.kind = rfc_pkg::KIND_VERDICT;
          r.dev_status = fr_status;
          r.pay_len = plen[10:0];
          if (~fr_crc != fr_rx_crc) r.verdict = rfc_pkg::VERDICT_BAD_CRC;
          else if (fr_status != 0) r.verdict = rfc_pkg::VERDICT_DEV_STATUS;
          else if (plen > fr_cap) r.verdict = rfc_pkg::VERDICT_TOO_LONG;
          else r.verdict = rfc_pkg::VERDICT_OK;
          fr_phase = FR_IDLE;
          fr_count = 0;
          got = 1'b1;
        end
      end
      default: ;
    endcase
    return got;
  endfunction

  task automatic report(input string msg);
    if (mismatch_count < 40) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (pending_beats.size() == 0) begin
          report($sformatf("beat with nothing expected, kind %0d", res_ch.kind));
        end else begin
          rfc_pkg::result_t want;
          want = pending_beats.pop_front();
          if (res_ch.kind != want.kind)
            report($sformatf("kind %0d, want %0d", res_ch.kind, want.kind));
          if (res_ch.data_byte != want.data_byte)
            report($sformatf("data_byte %0h, want %0h", res_ch.data_byte, want.data_byte));
          if (res_ch.verdict != want.verdict)
            report($sformatf("verdict %0d, want %0d", res_ch.verdict, want.verdict));
          if (res_ch.dev_status != want.dev_status)
            report($sformatf("dev_status %0h, want %0h", res_ch.dev_status,
                             want.dev_status));
          if (res_ch.pay_len != want.pay_len)
            report($sformatf("pay_len %0d, want %0d", res_ch.pay_len,
                             want.pay_len));
        end
      end
      if (sink_hold != 0) begin
        res_ch.ready <= 1'b0;
        sink_hold--;
      end else if (sink_steady || $urandom_range(0, 99) < 75) begin
        res_ch.ready <= 1'b1;
      end else begin
        sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        res_ch.ready <= 1'b0;
      end
      if ($urandom_range(0, 199) == 0) sink_steady = !sink_steady;
    end
  end

  task automatic send_item(input rfc_pkg::item_t it);
    int               gap;
    rfc_pkg::result_t r;
    gap = pick_gap();
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.op <= it.op;
    rx_ch.cmd_id <= it.cmd_id;
    rx_ch.expected_seq <= it.expected_seq;
    rx_ch.max_len <= it.max_len;
    rx_ch.rx_byte <= it.rx_byte;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    if (predict_beat(it, r)) pending_beats.push_back(r);
    items_sent++;
  endtask

  task automatic send_start(input logic [7:0] cmd, input logic [15:0] seq, input int cap);
    rfc_pkg::item_t it;
    it.op = rfc_pkg::OP_START;
    it.cmd_id = cmd;
    it.expected_seq = seq;
    it.max_len = 11'(cap);
    it.rx_byte = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    rfc_pkg::item_t it;
    it.op = rfc_pkg::OP_BYTE;
    it.cmd_id = 8'($urandom);
    it.expected_seq = 16'($urandom);
    it.max_len = 11'($urandom_range(0, PAYLOAD_CAP));
    it.rx_byte = b;
    send_item(it);
  endtask

  function automatic void make_frame(input logic [7:0] cmd_field, input logic [15:0] seq_field,
                                     input logic [15:0] len_field, input logic [15:0] status,
                                     input int npay);
    logic [31:0] c;
    frame_bytes.delete();
    for (int i = 0; i < 4; i++) frame_bytes.push_back(rfc_pkg::FRAME_MAGIC[8*i +: 8]);
    frame_bytes.push_back(rfc_pkg::FRAME_VERSION);
    frame_bytes.push_back(cmd_field);
    frame_bytes.push_back(seq_field[7:0]);
    frame_bytes.push_back(seq_field[15:8]);
    frame_bytes.push_back(len_field[7:0]);
    frame_bytes.push_back(len_field[15:8]);
    frame_bytes.push_back(status[7:0]);
    frame_bytes.push_back(status[15:8]);
    repeat (npay) frame_bytes.push_back(8'($urandom));
    c = '1;
    foreach (frame_bytes[i]) c = crc32_step(c, frame_bytes[i]);
    c = ~c;
    for (int i = 0; i < 4; i++) frame_bytes.push_back(c[8*i +: 8]);
  endfunction

  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] seq, input int cap,
                            input logic [7:0] cmd_field, input logic [15:0] seq_field,
                            input logic [15:0] len_field, input logic [15:0] status,
                            input int npay, input int flip_idx, input logic [7:0] flip_mask,
                            input int nsend);
    int n;
    make_frame(cmd_field, seq_field, len_field, status, npay);
    if (flip_idx >= 0 && flip_idx < frame_bytes.size()) frame_bytes[flip_idx] ^= flip_mask;
    n = (nsend < 0 || nsend > frame_bytes.size()) ? frame_bytes.size() : nsend;
    send_start(cmd, seq, cap);
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic send_clean(input logic [7:0] cmd, input logic [15:0] seq, input int cap,
                            input int npay, input logic [15:0] status);
    send_frame(cmd, seq, cap, cmd | rfc_pkg::REPLY_BIT, seq, 16'(npay + 2), status, npay,
               -1, 8'h00, -1);
  endtask

  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h52);
    send_byte(8'($urandom));
  endtask

  task automatic test_clean_frames();
    send_clean(8'h00, 16'h0000, 0, 0, 16'h0000);
    send_clean(8'hFF, 16'hFFFF, 5, 5, 16'h0000);
    send_clean(8'h5A, 16'h1234, 5, 6, 16'h0000);
    send_clean(8'h81, 16'h8000, 1024, 10, 16'hFFFF);
    send_clean(8'h3C, 16'h00FF, 100, 2, 16'h0100);
    send_clean(8'h92, 16'h7E01, 0, 4, 16'h0001);
    send_frame(8'h7F, 16'hA5A5, PAYLOAD_CAP, 8'hFF, 16'hA5A5, 16'(PAYLOAD_CAP + 2),
               16'h0000, PAYLOAD_CAP, -1, 8'h00, 14);
    send_frame(8'h44, 16'h0101, 64, 8'hC4, 16'h0101, 16'd9, 16'h0000, 7, 19, 8'h80, -1);
    send_frame(8'h45, 16'h0202, 0, 8'hC5, 16'h0202, 16'd4, 16'h8000, 2, 13, 8'h01, -1);
  endtask

  task automatic test_header_errors();
    send_frame(8'h21, 16'h0042, 64, 8'hA1, 16'h0042, 16'd6, 16'h0000, 4,
               $urandom_range(0, 3), 8'(1 << $urandom_range(0, 7)), -1);
    send_frame(8'h22, 16'h0043, 64, 8'hA2, 16'h0043, 16'd6, 16'h0000, 4, 4, 8'h01, -1);
    send_frame(8'h23, 16'h0044, 64, 8'hA3, 16'h0044, 16'd6, 16'h0000, 4, 4, 8'h03, -1);
    send_frame(8'h24, 16'h0045, 64, 8'hA4, 16'h0044, 16'd6, 16'h0000, 4, 0, 8'h40, -1);
    send_frame(8'h12, 16'h1000, 64, 8'h12, 16'h1000, 16'd4, 16'h0000, 2, -1, 8'h00, -1);
    send_frame(8'h13, 16'h1001, 64, 8'h93, 16'h9001, 16'd4, 16'h0000, 2, -1, 8'h00, -1);
    send_frame(8'h14, 16'h1002, 64, 8'h94, 16'h1003, 16'd4, 16'h0000, 2, -1, 8'h00, -1);
    send_frame(8'h15, 16'h1003, 64, 8'h95, 16'h1003, 16'd0, 16'h0000, 0, -1, 8'h00, -1);
    send_frame(8'h16, 16'h1004, 64, 8'h96, 16'h1004, 16'd1, 16'h0000, 0, -1, 8'h00, -1);
    send_frame(8'h17, 16'h1005, 64, 8'h97, 16'h1005, 16'(PAYLOAD_CAP + 3), 16'h0000, 0,
               -1, 8'h00, -1);
    send_frame(8'h18, 16'h1006, 64, 8'h98, 16'h1006, 16'hFFFF, 16'h0000, 0, -1, 8'h00, -1);
  endtask

  task automatic test_restart();
    send_frame(8'h31, 16'h2000, 16, 8'hB1, 16'h2000, 16'd10, 16'h0000, 8, -1, 8'h00, 5);
    send_frame(8'h32, 16'h2001, 16, 8'hB2, 16'h2001, 16'd10, 16'h0000, 8, -1, 8'h00, 14);
    send_frame(8'h33, 16'h2002, 16, 8'hB3, 16'h2002, 16'd10, 16'h0000, 8, -1, 8'h00, 22);
    send_start(8'h34, 16'h2003, 16);
    send_clean(8'h35, 16'h2004, 16, 3, 16'h0000);
  endtask

  function automatic int pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 16);
    if (r < 96) return $urandom_range(17, 80);
    return $urandom_range(81, 300);
  endfunction

  function automatic int pick_cap(input int npay);
    int r;
    int c;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      c = npay + $urandom_range(0, 4) - 2;
      return (c < 0) ? 0 : (c > PAYLOAD_CAP ? PAYLOAD_CAP : c);
    end
    if (r < 65) return $urandom_range(0, PAYLOAD_CAP);
    if (r < 80) return PAYLOAD_CAP;
    return $urandom_range(0, npay);
  endfunction

  function automatic logic [15:0] pick_status();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 16'h0000;
    if (r < 88) return 16'(1 << $urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  task automatic test_random_frames(input int count);
    int          goal;
    int          sel;
    int          npay;
    int          cap;
    logic [7:0]  cmd;
    logic [15:0] seq;
    logic [15:0] status;
    logic [15:0] len;
    goal = items_sent + count;
    while (items_sent < goal) begin
      tx_steady = ($urandom_range(0, 5) == 0);
      cmd = 8'($urandom);
      seq = 16'($urandom);
      npay = pick_payload();
      cap = pick_cap(npay);
      status = pick_status();
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        send_clean(cmd, seq, cap, npay, status);
      end else if (sel < 70) begin
        send_frame(cmd, seq, cap, cmd | rfc_pkg::REPLY_BIT, seq, 16'(npay + 2), status, npay,
                   $urandom_range(10, npay + 15), 8'(1 << $urandom_range(0, 7)), -1);
      end else if (sel < 77) begin
        send_frame(cmd, seq, cap, cmd | rfc_pkg::REPLY_BIT, seq, 16'(npay + 2), status, npay,
                   $urandom_range(0, 9), 8'(1 << $urandom_range(0, 7)), -1);
      end else if (sel < 83) begin
        send_frame(cmd, seq, cap, cmd | rfc_pkg::REPLY_BIT, seq, 16'(npay + 2), status, npay,
                   -1, 8'h00, $urandom_range(1, npay + 15));
      end else if (sel < 87) begin
        if ($urandom_range(0, 1) == 0)
          send_frame(cmd, seq, cap,
                     (cmd | rfc_pkg::REPLY_BIT) ^ 8'(1 << $urandom_range(0, 7)), seq,
                     16'(npay + 2), status, npay, -1, 8'h00, -1);
        else
          send_frame(cmd, seq, cap, cmd | rfc_pkg::REPLY_BIT,
                     seq ^ 16'(1 << $urandom_range(0, 15)),
                     16'(npay + 2), status, npay, -1, 8'h00, -1);
      end else if (sel < 91) begin
        len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1))
                                          : 16'($urandom_range(PAYLOAD_CAP + 3, 65535));
        send_frame(cmd, seq, cap, cmd | rfc_pkg::REPLY_BIT, seq, len, status,
                   $urandom_range(0, 3), -1, 8'h00, -1);
      end else if (sel < 95) begin
        send_start(cmd, seq, cap);
        repeat ($urandom_range(1, 30)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.op = rfc_pkg::OP_START;
    rx_ch.cmd_id = '0;
    rx_ch.expected_seq = '0;
    rx_ch.max_len = '0;
    rx_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    items_sent = 0;
    mismatch_count = 0;
    cycle_count = 0;
    sink_hold = 0;
    sink_steady = 1'b0;
    tx_steady = 1'b0;
    fr_phase = FR_IDLE;
    fr_count = 0;
    fr_crc = '1;
    fr_hdr_bad = 1'b0;
    fr_want_cmd = '0;
    fr_want_seq = '0;
    fr_cap = '0;
    fr_seq = '0;
    fr_cmd = '0;
    fr_len = '0;
    fr_status = '0;
    fr_rx_crc = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes();
    test_clean_frames();
    test_header_errors();
    test_restart();
    test_random_frames(830);
    rx_ch.valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && pending_beats.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_beats.size() != 0)
      report($sformatf("%0d expected beats never arrived", pending_beats.size()));
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
